// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define MKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define MKS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/mks_pkg.sv
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types and codes of the matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_SCAN   = 2'd2
  } phase_t;

  localparam logic FUNC_TICK      = 1'b0;
  localparam logic FUNC_MAP_WRITE = 1'b1;

  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [1:0] CFG_SETTLE_TICKS = 2'd2;

  localparam logic [3:0]  COLUMN_COUNT_RESET = 4'd8;
  localparam logic [3:0]  ROW_COUNT_RESET    = 4'd8;
  localparam logic [15:0] SETTLE_TICKS_RESET = 16'd10;

endpackage

// File: src/matrix_keypad_scanner.sv
// Rate: one transaction is accepted every clock cycle while results are taken;
// the result of a transaction passes through the keymap memory read register,
// then the output register. When the output stalls, one more transaction is
// still accepted into the read stage before in_ready drops.
// A tick in the scan phase compares one row; the keymap code of the
// last change is read from the keymap memory in the same cycle the scan ends.
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Row/column keypad scanner with settle delay, per-key state and keymap lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_keypad_scanner
  import mks_pkg::*;
#(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLUMNS = 8,
  parameter int CODE_BITS   = 10,
  localparam int MAP_SIZE   = MAX_ROWS * MAX_COLUMNS,
  localparam int AW         = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [MAX_COLUMNS-1:0] column_levels,
  input  logic [AW-1:0]          map_index,
  input  logic [CODE_BITS-1:0]   map_code,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MAX_ROWS-1:0]    row_drive,
  output logic                   event_valid,
  output logic [CODE_BITS-1:0]   key_code,
  output logic                   pressed,
  output logic                   scanning
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ECW = $clog2(MAX_COLUMNS + 1);
  localparam int ERW = $clog2(MAX_ROWS + 1);

  // configuration
  logic [3:0]  column_count;
  logic [3:0]  row_count;
  logic [15:0] settle_ticks;

  // scan state
  phase_t                 phase, phase_next;
  logic [15:0]            settle_left, settle_left_next;
  logic [RW-1:0]          scan_row, scan_row_next;
  logic [MAX_COLUMNS-1:0] last_columns, last_columns_next;
  logic [MAX_COLUMNS-1:0] key_state [MAX_ROWS];
  logic                   pending_valid, pending_valid_next;
  logic [AW-1:0]          pending_index, pending_index_next;
  logic                   pending_press, pending_press_next;

  logic [CODE_BITS-1:0]   keymap [MAP_SIZE];

  // read stage and output register
  logic                   s_valid;
  logic [MAX_ROWS-1:0]    s_row_drive;
  logic                   s_event;
  logic                   s_pressed;
  logic                   s_scanning;
  logic [CODE_BITS-1:0]   s_code;
  logic                   o_valid;
  logic [MAX_ROWS-1:0]    o_row_drive;
  logic                   o_event;
  logic                   o_pressed;
  logic                   o_scanning;
  logic [CODE_BITS-1:0]   o_code;

  logic                   in_fire;
  logic                   s_advance;
  logic                   tick;

  logic [ECW-1:0]         eff_cols;
  logic [ERW-1:0]         eff_rows;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [MAX_COLUMNS-1:0] levels;
  logic [MAX_COLUMNS-1:0] fall;
  logic [MAX_COLUMNS-1:0] row_state;
  logic [MAX_COLUMNS-1:0] row_diff;
  logic [MAX_COLUMNS-1:0] row_state_new;
  logic                   any_diff;
  logic [CIW-1:0]         hit_col;
  logic [AW-1:0]          lin_index;
  logic [RW:0]            row_inc;
  logic                   last_row;
  logic                   scan_tick;

  logic [MAX_ROWS-1:0]    row_drive_next;
  logic                   event_next;
  logic                   pressed_next;
  logic                   scanning_next;

  // handshakes
  assign cfg_ready = 1'b1;
  assign s_advance = s_valid && (!o_valid || out_ready);
  assign in_ready  = !s_valid || !o_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign tick      = (func == FUNC_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COLUMN_COUNT_RESET;
      row_count    <= ROW_COUNT_RESET;
      settle_ticks <= SETTLE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COLUMN_COUNT: column_count <= cfg_data[3:0];
        CFG_ROW_COUNT:    row_count    <= cfg_data[3:0];
        CFG_SETTLE_TICKS: settle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped counts and column decode
  always_comb begin
    if (column_count == 4'd0) begin
      eff_cols = ECW'(1);
    end else if (column_count > MAX_COLUMNS) begin
      eff_cols = ECW'(MAX_COLUMNS);
    end else begin
      eff_cols = ECW'(column_count);
    end
    if (row_count == 4'd0) begin
      eff_rows = ERW'(1);
    end else if (row_count > MAX_ROWS) begin
      eff_rows = ERW'(MAX_ROWS);
    end else begin
      eff_rows = ERW'(row_count);
    end
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = (ECW'(c) < eff_cols);
    end
  end

  assign levels        = column_levels | ~col_mask;
  assign fall          = last_columns & ~levels & col_mask;
  assign row_state     = key_state[scan_row];
  assign row_diff      = (row_state ^ levels) & col_mask;
  assign row_state_new = (row_state & ~col_mask) | (levels & col_mask);
  assign any_diff      = |row_diff;
  assign row_inc       = {1'b0, scan_row} + {{RW{1'b0}}, 1'b1};
  assign last_row      = (row_inc >= eff_rows);
  assign lin_index     = AW'(32'(scan_row) * 32'(eff_cols) + 32'(hit_col));
  assign scan_tick     = in_fire && tick && (phase == PH_SCAN);

  // last changed column in the row
  always_comb begin
    hit_col = '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (row_diff[c]) begin
        hit_col = CIW'(c);
      end
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    settle_left_next   = settle_left;
    scan_row_next      = scan_row;
    last_columns_next  = last_columns;
    pending_valid_next = pending_valid;
    pending_index_next = pending_index;
    pending_press_next = pending_press;
    if (tick) begin
      last_columns_next = levels;
      unique case (phase)
        PH_SETTLE: begin
          if (settle_left != 16'd0) begin
            settle_left_next = settle_left - 16'd1;
          end
          if (settle_left <= 16'd1) begin
            phase_next    = PH_SCAN;
            scan_row_next = '0;
          end
        end
        PH_SCAN: begin
          if (any_diff) begin
            pending_valid_next = 1'b1;
            pending_index_next = lin_index;
            pending_press_next = !levels[hit_col];
          end
          if (last_row) begin
            phase_next    = PH_IDLE;
            scan_row_next = '0;
          end else begin
            scan_row_next = row_inc[RW-1:0];
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (fall != '0) begin
            pending_valid_next = 1'b0;
            if (settle_ticks == 16'd0) begin
              phase_next    = PH_SCAN;
              scan_row_next = '0;
            end else begin
              phase_next       = PH_SETTLE;
              settle_left_next = settle_ticks;
            end
          end
        end
      endcase
    end
  end

  // result of this transaction
  always_comb begin
    event_next   = 1'b0;
    pressed_next = 1'b0;
    if (tick && phase == PH_SCAN && last_row) begin
      event_next   = pending_valid_next;
      pressed_next = pending_valid_next && pending_press_next;
    end
    scanning_next = (phase_next == PH_SETTLE) || (phase_next == PH_SCAN);
    for (int r = 0; r < MAX_ROWS; r++) begin
      row_drive_next[r] = (phase_next == PH_SCAN) && (scan_row_next != RW'(r));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      settle_left   <= '0;
      scan_row      <= '0;
      last_columns  <= '1;
      pending_valid <= 1'b0;
      pending_index <= '0;
      pending_press <= 1'b0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        key_state[r] <= '1;
      end
    end else if (in_fire) begin
      phase         <= phase_next;
      settle_left   <= settle_left_next;
      scan_row      <= scan_row_next;
      last_columns  <= last_columns_next;
      if (phase == PH_SCAN && last_row && tick) begin
        pending_valid <= 1'b0;
        pending_index <= '0;
        pending_press <= 1'b0;
      end else begin
        pending_valid <= pending_valid_next;
        pending_index <= pending_index_next;
        pending_press <= pending_press_next;
      end
      if (scan_tick) begin
        key_state[scan_row] <= row_state_new;
      end
    end
  end

  // keymap memory, registered read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (func == FUNC_MAP_WRITE && 32'(map_index) < MAP_SIZE) begin
        keymap[map_index] <= map_code;
      end
      s_code <= keymap[pending_index_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_fire) begin
      s_valid <= 1'b1;
    end else if (s_advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_row_drive <= row_drive_next;
      s_event     <= event_next;
      s_pressed   <= pressed_next;
      s_scanning  <= scanning_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_advance) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_advance) begin
      o_row_drive <= s_row_drive;
      o_event     <= s_event;
      o_pressed   <= s_pressed;
      o_scanning  <= s_scanning;
      o_code      <= s_event ? s_code : '0;
    end
  end

  assign out_valid   = o_valid;
  assign row_drive   = o_row_drive;
  assign event_valid = o_event;
  assign key_code    = o_code;
  assign pressed     = o_pressed;
  assign scanning    = o_scanning;

  `MKS_ASSERT_RST(a_rst_empties_out, rst |=> !o_valid, "output valid after reset")
  `MKS_ASSERT(a_settle_nonzero, phase == PH_SETTLE |-> settle_left != 16'd0, "settle count zero")
  `MKS_ASSERT(a_stage_drains, s_valid && !o_valid |=> o_valid, "read stage did not drain")
  `MKS_ASSERT(a_event_ends_scan, o_valid && o_event |-> !o_scanning && o_row_drive == '0, "event not at scan end")
  `MKS_ASSERT(a_quiet_code, o_valid && !o_event |-> o_code == '0, "code without event")

endmodule
